>>> design/mmao_pkg.sv
// Shared types, constants and helpers of the moving-average outlier filter.
package mmao_pkg;

  localparam int LANES       = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int LCNT_W      = 3;
  localparam int MAX_WINDOW_DEF = 16;
  localparam int QDEPTH      = 2;

  localparam int WL_REG_W    = 5;
  localparam logic [WL_REG_W-1:0] WL_RESET = 5'd8;
  localparam logic [LCNT_W-1:0]   NL_RESET = 3'd4;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // register index codes (paddr[2])
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LANES  = 1'b1;

  typedef logic [LANES-1:0][SAMPLE_BITS-1:0] lane_vec_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic        [LCNT_W-1:0]      lane_count;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_0;
    logic signed [SAMPLE_BITS-1:0] out_1;
    logic signed [SAMPLE_BITS-1:0] out_2;
    logic signed [SAMPLE_BITS-1:0] out_3;
    logic                          status;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    lane_vec_t          smp;
    logic [LCNT_W-1:0]  count;
    logic               err;
  } cmd_t;

  function automatic lane_vec_t unpack_in(input in_item_t d);
    lane_vec_t v;
    v[0] = d.sample_0;
    v[1] = d.sample_1;
    v[2] = d.sample_2;
    v[3] = d.sample_3;
    return v;
  endfunction

  function automatic out_item_t pack_out(input lane_vec_t v, input logic st);
    out_item_t o;
    o.out_0  = v[0];
    o.out_1  = v[1];
    o.out_2  = v[2];
    o.out_3  = v[3];
    o.status = st;
    return o;
  endfunction

endpackage

>>> design/mmao_queue.sv
// Small FIFO between pipeline sections.
module mmao_queue #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> design/mmao_front.sv
// Input stage: checks the lane count and builds the command for the back end.
module mmao_front (
  input  logic                    in_push,
  input  mmao_pkg::in_item_t      in_data,
  output logic                    in_full,
  input  logic [mmao_pkg::LCNT_W-1:0] nl_eff,
  input  logic                    q_full,
  output logic                    q_push,
  output mmao_pkg::cmd_t          q_data
);
  import mmao_pkg::*;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_data.smp   = unpack_in(in_data);
    q_data.count = in_data.lane_count;
    q_data.err   = (in_data.lane_count > nl_eff);
  end

endmodule

>>> design/mmao_back.sv
// Back end: window store, outlier substitution, window sums and averaging divide.
module mmao_back #(
  parameter int MAX_WINDOW = mmao_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              clr,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]   wl_eff,
  input  logic [mmao_pkg::LCNT_W-1:0]       nl_eff,
  input  logic                              cmd_empty,
  input  mmao_pkg::cmd_t                    cmd_data,
  output logic                              cmd_pop,
  input  logic                              res_full,
  output logic                              res_push,
  output mmao_pkg::out_item_t               res_data
);
  import mmao_pkg::*;

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WL_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DCNT_W = $clog2(MAG_W + 1);
  localparam int ROW_W  = LANES * SAMPLE_BITS;
  localparam int EXT_W  = SAMPLE_BITS + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MERGE = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_PREP  = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  cmd_t                    cmd_r;
  out_item_t               res_r;

  logic [ROW_W-1:0]        mem [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]   vld_r;
  logic [ROW_W-1:0]        rd_data_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [ROW_W-1:0]        row_new;
  lane_vec_t               out_lanes;

  logic [IDX_W-1:0]        idx_r, j_r;
  logic                    ready_r, pend_r;
  logic [SAMPLE_BITS-1:0]  avg_r [LANES];
  logic signed [SUM_W-1:0] acc_r [LANES];
  logic [MAG_W-1:0]        mag_r [LANES];
  logic [WL_W-1:0]         rem_r [LANES];
  logic [LANES-1:0]        neg_r;
  logic [DCNT_W-1:0]       dcnt_r;

  logic                    sum_last;
  logic [WL_W:0]           idx_inc;
  logic                    idx_wrap;

  assign sum_last = (WL_W'(j_r) == wl_eff - 1'b1);
  assign idx_inc  = {1'b0, WL_W'(idx_r)} + 1'b1;
  assign idx_wrap = (idx_inc >= {1'b0, wl_eff});

  assign cmd_pop  = (state_r == ST_IDLE) && !cmd_empty && !res_full;
  assign res_push = (state_r == ST_DONE);
  assign res_data = res_r;
  assign rd_addr  = (state_r == ST_IDLE) ? idx_r : j_r;
  assign mem_we   = (state_r == ST_MERGE);

  // merge new samples into the old row and decide substitution per lane
  always_comb begin
    logic [SAMPLE_BITS-1:0] old_s, x, a;
    logic signed [EXT_W-1:0] x2, a1, a3;
    logic in_lane;
    row_new   = '0;
    out_lanes = cmd_r.smp;
    for (int i = 0; i < LANES; i++) begin
      old_s   = rd_vld_r ? rd_data_r[i*SAMPLE_BITS +: SAMPLE_BITS] : '0;
      x       = cmd_r.smp[i];
      a       = avg_r[i];
      in_lane = (LCNT_W'(i) < cmd_r.count) && (x != '0);
      x2      = $signed({x[SAMPLE_BITS-1], x, 1'b0});
      a1      = $signed({{2{a[SAMPLE_BITS-1]}}, a});
      a3      = a1 + $signed({a[SAMPLE_BITS-1], a, 1'b0});
      row_new[i*SAMPLE_BITS +: SAMPLE_BITS] = in_lane ? x : old_s;
      if (in_lane && ready_r && (x2 > a1) && (x2 < a3)) begin
        out_lanes[i] = a;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          state_nxt = cmd_data.err ? ST_DONE : ST_MERGE;
        end
      end
      ST_MERGE: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = sum_last ? ST_DRAIN : ST_SUM;
      ST_DRAIN: state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (dcnt_r == DCNT_W'(1)) ? ST_DONE : ST_DIV;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // window memory, one row per index, all lanes side by side
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= row_new;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
      ready_r  <= 1'b0;
      pend_r   <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        avg_r[i] <= '0;
      end
    end else if (clr) begin
      state_r  <= ST_IDLE;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
      ready_r  <= 1'b0;
      pend_r   <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        avg_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= vld_r[rd_addr];
      pend_r   <= (state_r == ST_SUM);
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
      if ((state_r == ST_DONE) && !cmd_r.err) begin
        idx_r <= idx_wrap ? '0 : IDX_W'(idx_inc);
        if (idx_wrap) begin
          ready_r <= 1'b1;
        end
        for (int i = 0; i < LANES; i++) begin
          if (LCNT_W'(i) < nl_eff) begin
            avg_r[i] <= neg_r[i] ? SAMPLE_BITS'(-mag_r[i]) : SAMPLE_BITS'(mag_r[i]);
          end
        end
      end
    end
  end

  // datapath: item latch, accumulation and shift-subtract divide
  always_ff @(posedge clk) begin
    logic [WL_W:0] part;
    if (cmd_pop) begin
      cmd_r <= cmd_data;
      res_r <= pack_out(cmd_data.smp, 1'b1);
    end
    if (state_r == ST_MERGE) begin
      res_r <= pack_out(out_lanes, 1'b0);
      j_r   <= '0;
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= '0;
      end
    end
    if (state_r == ST_SUM) begin
      j_r <= j_r + 1'b1;
    end
    if (pend_r && rd_vld_r) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= acc_r[i] + SUM_W'($signed(rd_data_r[i*SAMPLE_BITS +: SAMPLE_BITS]));
      end
    end
    if (state_r == ST_PREP) begin
      dcnt_r <= DCNT_W'(MAG_W);
      for (int i = 0; i < LANES; i++) begin
        neg_r[i] <= acc_r[i][SUM_W-1];
        mag_r[i] <= acc_r[i][SUM_W-1] ? MAG_W'(-acc_r[i]) : MAG_W'(acc_r[i]);
        rem_r[i] <= '0;
      end
    end
    if (state_r == ST_DIV) begin
      dcnt_r <= dcnt_r - 1'b1;
      for (int i = 0; i < LANES; i++) begin
        part = {rem_r[i], mag_r[i][MAG_W-1]};
        if (part >= {1'b0, wl_eff}) begin
          rem_r[i] <= WL_W'(part - {1'b0, wl_eff});
          mag_r[i] <= {mag_r[i][MAG_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= WL_W'(part);
          mag_r[i] <= {mag_r[i][MAG_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

>>> design/multichannel_moving_average_outlier.sv
// Top level: config registers, front end, command and result queues, back end.
//
//  channel   direction  handshake                   payload
//  in_       input      in_push / in_full           in_data   (in_item_t)
//  out_      output     out_pop / out_empty         out_data  (out_item_t)
//  config    APB write  psel penable pwrite pready  paddr, pwdata, prdata
//
// An accepted item with a legal lane count occupies the back end through the
// merge, sum, drain, prep and divide states: one window row is summed per
// cycle over the single memory read port, then a one-bit-per-cycle shift-subtract
// divide per lane. An item with too many lanes skips to the result with its
// samples unchanged and status set. rst_n is synchronous; reset and any config
// write clear the window valid bits, averages and index at once. Two-entry
// queues on both sides let the input keep taking beats while a result waits
// to be popped.
module multichannel_moving_average_outlier #(
  parameter int MAX_WINDOW = mmao_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input queue side
  input  logic                               in_push,
  input  mmao_pkg::in_item_t                 in_data,
  output logic                               in_full,
  // result queue side
  output logic                               out_empty,
  input  logic                               out_pop,
  output mmao_pkg::out_item_t                out_data,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mmao_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mmao_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mmao_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import mmao_pkg::*;

  localparam int WL_W = $clog2(MAX_WINDOW + 1);

  logic [WL_REG_W-1:0] wl_r;
  logic [LCNT_W-1:0]   nl_r;
  logic [WL_W-1:0]     wl_eff;
  logic [LCNT_W-1:0]   nl_eff;
  logic                cfg_wr;
  logic                reg_sel;

  logic                cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
  cmd_t                cmdq_wdata, cmdq_rdata;
  logic                res_push, outq_full;
  out_item_t           res_data;
  logic [$bits(out_item_t)-1:0] outq_rdata;

  // ---------------------------------------------------------------------------
  // Config registers. Register index is paddr[2]; every write also clears the
  // filter state.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= WL_RESET;
      nl_r <= NL_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_WINDOW: wl_r <= pwdata[WL_REG_W-1:0];
        REG_LANES:  nl_r <= pwdata[LCNT_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WINDOW: prdata = CFG_DATA_W'(wl_r);
      REG_LANES:  prdata = CFG_DATA_W'(nl_r);
      default:    prdata = '0;
    endcase
  end

  // Out-of-range settings: zero acts as one, too large clamps to the maximum.
  always_comb begin
    if (wl_r == '0) begin
      wl_eff = WL_W'(1);
    end else if (32'(wl_r) > 32'(MAX_WINDOW)) begin
      wl_eff = WL_W'(MAX_WINDOW);
    end else begin
      wl_eff = WL_W'(wl_r);
    end
    if (nl_r == '0) begin
      nl_eff = LCNT_W'(1);
    end else if (32'(nl_r) > 32'(LANES)) begin
      nl_eff = LCNT_W'(LANES);
    end else begin
      nl_eff = nl_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: classify the beat, queue it for the back end
  // ---------------------------------------------------------------------------
  mmao_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .nl_eff  (nl_eff),
    .q_full  (cmdq_full),
    .q_push  (cmdq_push),
    .q_data  (cmdq_wdata)
  );

  mmao_queue #(
    .W     ($bits(cmd_t)),
    .DEPTH (QDEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmdq_push),
    .wdata (cmdq_wdata),
    .full  (cmdq_full),
    .pop   (cmdq_pop),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty)
  );

  // ---------------------------------------------------------------------------
  // Back end: one item at a time; it only starts when a result slot is free,
  // so its push never meets a full result queue.
  // ---------------------------------------------------------------------------
  mmao_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr),
    .wl_eff    (wl_eff),
    .nl_eff    (nl_eff),
    .cmd_empty (cmdq_empty),
    .cmd_data  (cmdq_rdata),
    .cmd_pop   (cmdq_pop),
    .res_full  (outq_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  mmao_queue #(
    .W     ($bits(out_item_t)),
    .DEPTH (QDEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (outq_full),
    .pop   (out_pop),
    .rdata (outq_rdata),
    .empty (out_empty)
  );

  assign out_data = out_item_t'(outq_rdata);

`ifndef SYNTH
  // result slot is reserved when the back end starts an item
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !outq_full)
    else $error("result pushed into full queue");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_pop |-> !outq_full)
    else $error("item started without a free result slot");

  a_result_seen: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !out_empty)
    else $error("pushed result not visible");
`endif

endmodule
